### hw/rtl/rsm_pkg.sv
// rsm_pkg: shared constants and word types for the random sampling multiset.
// No dependencies.
package rsm_pkg;

  localparam int CAPACITY    = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int FILL_W      = IDX_W + 1;
  localparam int RANK_W      = IDX_W;
  localparam int RW_W        = 31;
  localparam int STEP_W      = $clog2(RW_W);

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] item_value;
    logic [RW_W-1:0]    random_word;
  } in_word_t;

  typedef struct packed {
    logic               flag;
    logic signed [31:0] sampled_value;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [RANK_W-1:0]      rank;
  } slot_t;

endpackage

### hw/rtl/random_sampling_multiset_top.sv
// Multiset of up to 256 values in a dense slot memory with insert, remove
// and uniform sample. One word at a time: insert and remove scan every
// occupied slot through the memory read port, one slot per cycle; a sample
// runs a 31-step serial remainder unit and then a memory read. A result waits
// in the output register until taken. Depends on rsm_pkg, rsm_ram, rsm_mod.
module random_sampling_multiset_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rsm_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rsm_pkg::out_word_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_MOVE, ST_MOD, ST_SAMP, ST_DONE
  } state_t;

  state_t                       state_r;
  logic [1:0]                   kind_r;
  logic [rsm_pkg::VALUE_WIDTH-1:0] val_r;
  logic [rsm_pkg::FILL_W-1:0]   fill_r;
  logic [rsm_pkg::FILL_W-1:0]   addr_r;
  logic                         pend_r;
  logic [rsm_pkg::IDX_W-1:0]    pend_idx_r;
  logic [rsm_pkg::RANK_W-1:0]   cnt_r;
  logic                         found_r;
  logic [rsm_pkg::IDX_W-1:0]    hit_r;
  logic [rsm_pkg::RANK_W-1:0]   best_r;
  rsm_pkg::out_word_t           res_r;
  logic                         out_valid_r;
  rsm_pkg::out_word_t           out_data_r;

  logic                         we;
  logic [rsm_pkg::IDX_W-1:0]    waddr;
  rsm_pkg::slot_t               wdata;
  logic [rsm_pkg::IDX_W-1:0]    raddr;
  rsm_pkg::slot_t               rdata;
  logic                         mod_start;
  logic                         mod_done;
  logic [rsm_pkg::IDX_W-1:0]    mod_rem;
  logic                         scan_done;
  logic                         match;
  logic [rsm_pkg::FILL_W-1:0]   last;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign scan_done = (state_r == ST_SCAN) && (addr_r == fill_r) && !pend_r;
  assign match     = pend_r && (rdata.value == val_r);
  assign last      = fill_r - 1'b1;
  assign mod_start = (state_r == ST_IDLE) && in_valid && (in_data.kind == rsm_pkg::KIND_SAMPLE)
                     && (fill_r != '0);

  rsm_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rsm_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_data.random_word),
    .divisor  (fill_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    we    = 1'b0;
    waddr = fill_r[rsm_pkg::IDX_W-1:0];
    wdata = '{value: val_r, rank: cnt_r};
    raddr = addr_r[rsm_pkg::IDX_W-1:0];
    if (scan_done && kind_r == rsm_pkg::KIND_INSERT) begin
      we = 1'b1;
    end
    if (scan_done && kind_r == rsm_pkg::KIND_REMOVE) begin
      raddr = last[rsm_pkg::IDX_W-1:0];
    end
    if (state_r == ST_MOVE) begin
      we    = 1'b1;
      waddr = hit_r;
      wdata = rdata;
    end
    if (state_r == ST_MOD) begin
      raddr = mod_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            kind_r              <= in_data.kind;
            val_r               <= in_data.item_value;
            addr_r              <= '0;
            pend_r              <= 1'b0;
            cnt_r               <= '0;
            found_r             <= 1'b0;
            best_r              <= '0;
            hit_r               <= '0;
            res_r.flag          <= 1'b0;
            res_r.sampled_value <= '0;
            case (in_data.kind)
              rsm_pkg::KIND_INSERT: begin
                if (fill_r == rsm_pkg::FILL_W'(rsm_pkg::CAPACITY)) begin
                  res_r.status <= rsm_pkg::STATUS_FULL;
                  state_r      <= ST_DONE;
                end else begin
                  res_r.status <= rsm_pkg::STATUS_OK;
                  state_r      <= ST_SCAN;
                end
              end
              rsm_pkg::KIND_REMOVE: begin
                res_r.status <= rsm_pkg::STATUS_OK;
                state_r      <= ST_SCAN;
              end
              rsm_pkg::KIND_SAMPLE: begin
                if (fill_r == '0) begin
                  res_r.status <= rsm_pkg::STATUS_EMPTY;
                  state_r      <= ST_DONE;
                end else begin
                  res_r.status <= rsm_pkg::STATUS_OK;
                  state_r      <= ST_MOD;
                end
              end
              default: begin
                res_r.status <= rsm_pkg::STATUS_OK;
                state_r      <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (addr_r != fill_r) begin
            pend_r     <= 1'b1;
            pend_idx_r <= addr_r[rsm_pkg::IDX_W-1:0];
            addr_r     <= addr_r + 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          if (match) begin
            cnt_r <= cnt_r + 1'b1;
            if (!found_r || rdata.rank >= best_r) begin
              found_r <= 1'b1;
              hit_r   <= pend_idx_r;
              best_r  <= rdata.rank;
            end
          end
          if (scan_done) begin
            if (kind_r == rsm_pkg::KIND_INSERT) begin
              fill_r     <= fill_r + 1'b1;
              res_r.flag <= (cnt_r == '0);
              state_r    <= ST_DONE;
            end else if (found_r) begin
              state_r <= ST_MOVE;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_MOVE: begin
          fill_r     <= last;
          res_r.flag <= 1'b1;
          state_r    <= ST_DONE;
        end
        ST_MOD: begin
          if (mod_done) begin
            state_r <= ST_SAMP;
          end
        end
        ST_SAMP: begin
          res_r.sampled_value <= rdata.value;
          state_r             <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_data_r <= res_r;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/rsm_ram.sv
// rsm_ram: slot memory, one write port, one read port, registered read data.
// Depends on rsm_pkg.
module rsm_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [rsm_pkg::IDX_W-1:0] waddr,
  input  rsm_pkg::slot_t           wdata,
  input  logic [rsm_pkg::IDX_W-1:0] raddr,
  output rsm_pkg::slot_t           rdata
);

  rsm_pkg::slot_t mem [rsm_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/rsm_mod.sv
// rsm_mod: bit-serial restoring remainder of random word by fill count.
// Depends on rsm_pkg.
module rsm_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rsm_pkg::RW_W-1:0]   dividend,
  input  logic [rsm_pkg::FILL_W-1:0] divisor,
  output logic                       done,
  output logic [rsm_pkg::IDX_W-1:0]  rem
);

  logic [rsm_pkg::RW_W-1:0]   quo_r;
  logic [rsm_pkg::FILL_W-1:0] div_r;
  logic [rsm_pkg::FILL_W-1:0] rem_r;
  logic [rsm_pkg::STEP_W-1:0] cnt_r;
  logic                       run_r;
  logic                       done_r;
  logic [rsm_pkg::FILL_W:0]   trial;

  assign trial = {rem_r, quo_r[rsm_pkg::RW_W-1]};
  assign done  = done_r;
  assign rem   = rem_r[rsm_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        run_r  <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= '0;
        quo_r  <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
      end else if (run_r) begin
        quo_r <= quo_r << 1;
        if (trial >= {1'b0, div_r}) begin
          rem_r <= rsm_pkg::FILL_W'(trial - {1'b0, div_r});
        end else begin
          rem_r <= trial[rsm_pkg::FILL_W-1:0];
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rsm_pkg::STEP_W'(rsm_pkg::RW_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

endmodule

### test/random_sampling_multiset_top_tb.sv
// Testbench for random_sampling_multiset_top: drives insert, remove and sample
// words, predicts each result with a behavioral multiset, compares field by field.
// Depends on rsm_pkg and the block's RTL.
`timescale 1ns / 1ps

module random_sampling_multiset_top_tb;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  rsm_pkg::in_word_t in_data;
  logic out_valid;
  logic out_ready;
  rsm_pkg::out_word_t out_data;

  random_sampling_multiset_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  rsm_pkg::in_word_t pending_words[$];
  rsm_pkg::out_word_t expected_results[$];

  logic [31:0] store_value[rsm_pkg::CAPACITY];
  logic [7:0] store_rank[rsm_pkg::CAPACITY];
  int fill;

  int errors;
  int cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off;

  localparam int CYCLE_LIMIT = 2000000;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic rsm_pkg::out_word_t multiset_step(rsm_pkg::in_word_t w);
    rsm_pkg::out_word_t r;
    int n;
    int hit;
    int best;
    bit found;
    r = '0;
    if (w.kind == rsm_pkg::KIND_INSERT) begin
      if (fill >= rsm_pkg::CAPACITY) begin
        r.status = rsm_pkg::STATUS_FULL;
      end else begin
        n = 0;
        for (int i = 0; i < fill; i++) if (store_value[i] == w.item_value) n++;
        r.flag = (n == 0);
        store_value[fill] = w.item_value;
        store_rank[fill] = n[7:0];
        fill++;
      end
    end else if (w.kind == rsm_pkg::KIND_REMOVE) begin
      found = 0;
      hit = 0;
      best = 0;
      for (int i = 0; i < fill; i++) begin
        if (store_value[i] == w.item_value && (!found || store_rank[i] >= best)) begin
          found = 1;
          hit = i;
          best = store_rank[i];
        end
      end
      if (found) begin
        store_value[hit] = store_value[fill-1];
        store_rank[hit] = store_rank[fill-1];
        fill--;
        r.flag = 1'b1;
      end
    end else if (w.kind == rsm_pkg::KIND_SAMPLE) begin
      if (fill == 0) r.status = rsm_pkg::STATUS_EMPTY;
      else r.sampled_value = store_value[w.random_word % fill];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_results.insert(expected_results.size(), multiset_step(in_data));
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", out_data.sampled_value, 32'd0);
      end else begin
        rsm_pkg::out_word_t e;
        e = expected_results.pop_front();
        if (out_data.flag !== e.flag)
          report_mismatch("flag", 32'(out_data.flag), 32'(e.flag));
        if (out_data.sampled_value !== e.sampled_value)
          report_mismatch("sampled_value", out_data.sampled_value, e.sampled_value);
        if (out_data.status !== e.status)
          report_mismatch("status", 32'(out_data.status), 32'(e.status));
      end
    end
  end

  // receiver ready with idling and long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic rsm_pkg::in_word_t make_word(logic [1:0] k, logic [31:0] v,
                                                  logic [31:0] rw);
    rsm_pkg::in_word_t w;
    w.kind = k;
    w.item_value = v;
    w.random_word = rw[30:0];
    return w;
  endfunction

  task automatic queue_word(rsm_pkg::in_word_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [31:0] pool[16];
    int r;
    logic [1:0] k;
    errors = 0;
    cycles = 0;
    hold_off = 0;
    fill = 0;
    send_idle_pct = 15;
    recv_idle_pct = 69;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_data = '0;
    for (int i = 0; i < 16; i++) pool[i] = $urandom;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0;
    pool[3] = 32'hffff_ffff;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty sample, absent remove, extremes, duplicates, unused kind
    queue_word(make_word(rsm_pkg::KIND_SAMPLE, 0, 32'h7fff_ffff));
    queue_word(make_word(rsm_pkg::KIND_REMOVE, 32'h5, 0));
    queue_word(make_word(rsm_pkg::KIND_INSERT, 32'h8000_0000, 0));
    queue_word(make_word(rsm_pkg::KIND_INSERT, 32'h7fff_ffff, 0));
    queue_word(make_word(rsm_pkg::KIND_INSERT, 32'h7fff_ffff, 0));
    queue_word(make_word(rsm_pkg::KIND_INSERT, 32'h0, 0));
    queue_word(make_word(rsm_pkg::KIND_INSERT, 32'hffff_ffff, 0));
    queue_word(make_word(rsm_pkg::KIND_INSERT, 32'h7fff_ffff, 0));
    for (int i = 0; i < 5; i++)
      queue_word(make_word(rsm_pkg::KIND_SAMPLE, 0, i == 4 ? 32'h7fff_ffff : i));
    queue_word(make_word(rsm_pkg::KIND_REMOVE, 32'h7fff_ffff, 0));
    queue_word(make_word(rsm_pkg::KIND_SAMPLE, 32'hffff_ffff, 32'h5555_5555));
    queue_word(make_word(2'd3, 32'h1234, 32'h1));
    queue_word(make_word(rsm_pkg::KIND_REMOVE, 32'h8000_0000, 0));
    queue_word(make_word(rsm_pkg::KIND_REMOVE, 32'h8000_0000, 0));
    queue_word(make_word(rsm_pkg::KIND_SAMPLE, 0, 32'h2aaa_aaaa));

    // fill to capacity, then full inserts, then back down
    for (int i = 0; i < 260; i++)
      queue_word(make_word(rsm_pkg::KIND_INSERT, pool[$urandom_range(15)], 0));
    queue_word(make_word(rsm_pkg::KIND_SAMPLE, 0, $urandom));
    for (int i = 0; i < 40; i++) begin
      r = $urandom_range(2);
      queue_word(make_word(r[1:0], pool[$urandom_range(15)], $urandom));
    end
    wait_drained();
    hold_off = 1500;
    for (int i = 0; i < 60; i++)
      queue_word(make_word(rsm_pkg::KIND_REMOVE, pool[$urandom_range(15)], 0));
    wait_drained();

    send_idle_pct = 69;
    recv_idle_pct = 15;
    for (int i = 0; i < 300; i++) begin
      r = $urandom_range(99);
      k = r < 40 ? rsm_pkg::KIND_INSERT : r < 75 ? rsm_pkg::KIND_REMOVE :
          r < 98 ? rsm_pkg::KIND_SAMPLE : 2'd3;
      queue_word(make_word(k, r < 80 ? pool[$urandom_range(15)] : $urandom, $urandom));
    end
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 260; i++) begin
      r = $urandom_range(99);
      k = r < 45 ? rsm_pkg::KIND_INSERT : r < 75 ? rsm_pkg::KIND_REMOVE : rsm_pkg::KIND_SAMPLE;
      queue_word(make_word(k, pool[$urandom_range(15)],
                           $urandom_range(1) ? $urandom : $urandom_range(300)));
    end
    wait_drained();
    repeat (600) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

### random_sampling_multiset_top.f
hw/rtl/rsm_pkg.sv
hw/rtl/rsm_ram.sv
hw/rtl/rsm_mod.sv
hw/rtl/random_sampling_multiset_top.sv
test/random_sampling_multiset_top_tb.sv
